// File: rtl/emc_pkg.sv
// Shared types, codes and constant tables for the encoder menu controller.
package emc_pkg;

	localparam int unsigned UV_W = 24;
	localparam int unsigned STEP_W = 20;

	localparam logic [UV_W-1:0] LIMIT_RESET = 24'd15000000;
	localparam logic [UV_W-1:0] SETPOINT_RESET = 24'd10000000;
	localparam logic [UV_W-1:0] REFERENCE_RESET = 24'd10900000;

	localparam logic ACTION_POLL = 1'b0;
	localparam logic ACTION_LOAD = 1'b1;

	localparam logic [1:0] KEY_NONE = 2'd0;
	localparam logic [1:0] KEY_OK_SHORT = 2'd1;
	localparam logic [1:0] KEY_OK_LONG = 2'd2;

	localparam logic [1:0] LEVEL_ROOT = 2'd0;
	localparam logic [1:0] LEVEL_LIST = 2'd1;
	localparam logic [1:0] LEVEL_SHOW = 2'd2;
	localparam logic [1:0] LEVEL_ADJUST = 2'd3;

	localparam logic [1:0] MENU_VOLTAGE = 2'd0;
	localparam logic [1:0] MENU_CODE = 2'd1;
	localparam logic [1:0] MENU_CALIBRATE = 2'd2;
	localparam logic [1:0] MENU_TEMPERATURE = 2'd3;

	localparam logic [3:0] LED_ROOT = 4'd9;
	localparam logic [3:0] LED_NONE = 4'd0;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_HIGHLIGHT = 2'd1;
	localparam logic [1:0] MODE_BLINK = 2'd2;

	localparam logic [2:0] CURSOR_MAX_POS = 3'd6;

	typedef struct packed {
		logic action;
		logic [7:0] encoder_count;
		logic [1:0] key_code;
		logic [UV_W-1:0] voltage_uv;
	} item_t;

	typedef struct packed {
		logic refresh;
		logic [1:0] level;
		logic [1:0] selected_menu;
		logic [3:0] cursor_led;
		logic [1:0] cursor_mode;
		logic [UV_W-1:0] setting_uv;
		logic [UV_W-1:0] reference_now_uv;
		logic apply_setting;
	} result_t;

	function automatic logic [STEP_W-1:0] step_for_pos(input logic [2:0] pos);
		logic [STEP_W-1:0] s;
		case (pos)
			3'd0: s = 20'd1000000;
			3'd1: s = 20'd100000;
			3'd2: s = 20'd10000;
			3'd3: s = 20'd1000;
			3'd4: s = 20'd100;
			3'd5: s = 20'd10;
			default: s = 20'd1;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] cursor_offset(input logic [1:0] menu);
		logic [3:0] o;
		case (menu)
			MENU_VOLTAGE: o = 4'd2;
			MENU_CODE: o = 4'd3;
			MENU_CALIBRATE: o = 4'd2;
			default: o = 4'd0;
		endcase
		return o;
	endfunction

	function automatic logic [2:0] cursor_top(input logic [1:0] menu);
		logic [2:0] t;
		case (menu)
			MENU_CODE: t = 3'd4;
			default: t = 3'd6;
		endcase
		return t;
	endfunction

endpackage

// File: rtl/emc_nudge.sv
// Adjust unit: adds delta times a power of ten; rejects sums at or over the limit, clamps below zero to zero.
module emc_nudge (
	input  logic [emc_pkg::UV_W-1:0] value,
	input  logic [emc_pkg::UV_W-1:0] limit,
	input  logic signed [7:0]        delta,
	input  logic [2:0]               pos,
	output logic [emc_pkg::UV_W-1:0] result
);

	logic [2:0] pos_c;
	logic [emc_pkg::STEP_W-1:0] step;
	logic signed [emc_pkg::STEP_W+8:0] prod;
	logic signed [31:0] cand;
	logic signed [31:0] limit_s;

	always_comb begin
		pos_c = (pos > emc_pkg::CURSOR_MAX_POS) ? emc_pkg::CURSOR_MAX_POS : pos;
		step = emc_pkg::step_for_pos(pos_c);
		prod = delta * $signed({1'b0, step});
		cand = $signed({8'd0, value}) + 32'(prod);
		limit_s = $signed({8'd0, limit});
		if (cand < limit_s) begin
			if (cand < 0) begin
				result = '0;
			end else begin
				result = cand[emc_pkg::UV_W-1:0];
			end
		end else begin
			result = value;
		end
	end

endmodule

// File: rtl/emc_core.sv
// Menu state registers and the navigation logic that updates them per item.
module emc_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  emc_pkg::item_t           item,
	input  logic [emc_pkg::UV_W-1:0] limit,
	output emc_pkg::result_t         result
);

	logic [1:0] depth_q, depth_d;
	logic [1:0] index_q, index_d;
	logic [2:0] cursor_q, cursor_d;
	logic [emc_pkg::UV_W-1:0] setpoint_q, setpoint_d;
	logic [emc_pkg::UV_W-1:0] reference_q, reference_d;
	logic [7:0] last_enc_q, last_enc_d;
	logic [1:0] last_key_q, last_key_d;
	logic pending_q, pending_d;

	logic signed [7:0] delta;
	logic changed;
	logic apply;
	logic refresh;
	logic signed [9:0] m_sum;
	logic signed [9:0] c_sum;
	logic [2:0] top;
	logic adjust_ref;
	logic [emc_pkg::UV_W-1:0] nudge_value;
	logic [emc_pkg::UV_W-1:0] nudge_limit;
	logic [emc_pkg::UV_W-1:0] nudge_out;

	assign delta = $signed(item.encoder_count - last_enc_q);
	assign adjust_ref = (index_q == emc_pkg::MENU_CALIBRATE);
	assign nudge_value = adjust_ref ? reference_q : setpoint_q;
	assign nudge_limit = adjust_ref ? limit : reference_q;

	emc_nudge u_nudge (
		.value (nudge_value),
		.limit (nudge_limit),
		.delta (delta),
		.pos   (cursor_q),
		.result(nudge_out)
	);

	always_comb begin
		depth_d = depth_q;
		index_d = index_q;
		cursor_d = cursor_q;
		setpoint_d = setpoint_q;
		reference_d = reference_q;
		last_enc_d = last_enc_q;
		last_key_d = last_key_q;
		pending_d = pending_q;
		apply = 1'b0;
		refresh = 1'b0;
		changed = (item.encoder_count != last_enc_q) || (item.key_code != last_key_q);
		m_sum = $signed({8'd0, index_q}) + 10'(delta);
		c_sum = $signed({7'd0, cursor_q}) + 10'(delta);
		top = emc_pkg::cursor_top(index_q);

		if (item.action == emc_pkg::ACTION_LOAD) begin
			setpoint_d = item.voltage_uv;
			pending_d = 1'b1;
		end else begin
			if (changed) begin
				last_enc_d = item.encoder_count;
				last_key_d = item.key_code;
				if (delta != 0 || item.key_code != emc_pkg::KEY_NONE) begin
					pending_d = 1'b1;
				end
				if (item.key_code == emc_pkg::KEY_OK_SHORT) begin
					if (depth_q == emc_pkg::LEVEL_ADJUST) begin
						depth_d = emc_pkg::LEVEL_SHOW;
					end else if (depth_q == emc_pkg::LEVEL_SHOW &&
							index_q == emc_pkg::MENU_TEMPERATURE) begin
						depth_d = emc_pkg::LEVEL_ROOT;
					end else begin
						depth_d = depth_q + 2'd1;
					end
				end else if (item.key_code == emc_pkg::KEY_OK_LONG) begin
					depth_d = emc_pkg::LEVEL_ROOT;
				end else if (delta != 0) begin
					case (depth_q)
						emc_pkg::LEVEL_LIST: begin
							if (m_sum < 0) begin
								index_d = 2'd0;
							end else if (m_sum > 10'sd3) begin
								index_d = 2'd3;
							end else begin
								index_d = m_sum[1:0];
							end
						end
						emc_pkg::LEVEL_SHOW: begin
							if (index_q != emc_pkg::MENU_TEMPERATURE) begin
								if (c_sum < 0) begin
									cursor_d = 3'd0;
								end else if (c_sum > $signed({7'd0, top})) begin
									cursor_d = top;
								end else begin
									cursor_d = c_sum[2:0];
								end
							end
						end
						emc_pkg::LEVEL_ADJUST: begin
							if (index_q == emc_pkg::MENU_VOLTAGE) begin
								setpoint_d = nudge_out;
								apply = 1'b1;
							end else if (index_q == emc_pkg::MENU_CALIBRATE) begin
								reference_d = nudge_out;
							end
						end
						default: begin
						end
					endcase
				end
			end
			refresh = pending_d;
			pending_d = 1'b0;
		end

		result.refresh = refresh;
		result.level = depth_d;
		result.selected_menu = index_d;
		result.setting_uv = setpoint_d;
		result.reference_now_uv = reference_d;
		result.apply_setting = apply;
		if (depth_d == emc_pkg::LEVEL_ROOT) begin
			result.cursor_led = emc_pkg::LED_ROOT;
			result.cursor_mode = emc_pkg::MODE_BLINK;
		end else if (depth_d != emc_pkg::LEVEL_LIST &&
				index_d != emc_pkg::MENU_TEMPERATURE) begin
			result.cursor_led = {1'b0, cursor_d} + emc_pkg::cursor_offset(index_d);
			result.cursor_mode = (depth_d == emc_pkg::LEVEL_SHOW) ?
				emc_pkg::MODE_HIGHLIGHT : emc_pkg::MODE_BLINK;
		end else begin
			result.cursor_led = emc_pkg::LED_NONE;
			result.cursor_mode = emc_pkg::MODE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= emc_pkg::LEVEL_ROOT;
			index_q <= emc_pkg::MENU_VOLTAGE;
			cursor_q <= 3'd0;
			setpoint_q <= emc_pkg::SETPOINT_RESET;
			reference_q <= emc_pkg::REFERENCE_RESET;
			last_enc_q <= 8'd0;
			last_key_q <= emc_pkg::KEY_NONE;
			pending_q <= 1'b1;
		end else if (take) begin
			depth_q <= depth_d;
			index_q <= index_d;
			cursor_q <= cursor_d;
			setpoint_q <= setpoint_d;
			reference_q <= reference_d;
			last_enc_q <= last_enc_d;
			last_key_q <= last_key_d;
			pending_q <= pending_d;
		end
	end

endmodule

// File: rtl/encoder_menu_controller.sv
// Top level of the encoder menu controller: input register, menu core, result register.
// An accepted item is held in the input register; its result passes through the result register to the master side.
// Throughput: one item per cycle unless stalled; the core's next state is combinational.
// A stalled master side holds the result register and the input register backs up behind it.
// Reset (arst_n low, asynchronous) empties both registers, returns the menu to root with
// setpoint 10000000 uV, reference 10900000 uV, limit 15000000 uV and a redraw pending.
module encoder_menu_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // encoder_count[7:0], key_code[9:8], voltage_uv[33:10], zeros
	input  logic        s_tuser,  // action[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // refresh[0], level[2:1], selected_menu[4:3],
	                              // cursor_led[8:5], cursor_mode[10:9], setting_uv[34:11],
	                              // reference_now_uv[58:35], apply_setting[59], zeros
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata
);

	emc_pkg::item_t item_s1;
	logic valid_s1;
	emc_pkg::result_t core_result;
	emc_pkg::result_t result_s2;
	logic valid_s2;
	logic [emc_pkg::UV_W-1:0] limit_q;
	logic out_free;
	logic advance;

	assign out_free = !valid_s2 || m_tready;
	assign advance = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= emc_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.action <= s_tuser;
			item_s1.encoder_count <= s_tdata[7:0];
			item_s1.key_code <= s_tdata[9:8];
			item_s1.voltage_uv <= s_tdata[33:10];
		end
	end

	emc_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (advance),
		.item  (item_s1),
		.limit (limit_q),
		.result(core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= core_result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {4'd0,
		result_s2.apply_setting,
		result_s2.reference_now_uv,
		result_s2.setting_uv,
		result_s2.cursor_mode,
		result_s2.cursor_led,
		result_s2.selected_menu,
		result_s2.level,
		result_s2.refresh};

endmodule

// File: bench/encoder_menu_controller_tb.sv
// Self-checking testbench for the encoder menu controller against a menu predictor.
module encoder_menu_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KEY_OTHER = 2'd3;
	localparam logic [3:0] VALUE_DIGIT_OFFSET = 4'd2;
	localparam logic [3:0] CODE_DIGIT_OFFSET = 4'd3;
	localparam int PHASE_ITEMS = 325;
	localparam int CYCLE_LIMIT = 500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;  // encoder_count[7:0], key_code[9:8], voltage_uv[33:10], zeros
	logic s_tuser = 1'b0;       // action[0]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;       // refresh[0], level[2:1], selected_menu[4:3], cursor_led[8:5],
	                            // cursor_mode[10:9], setting_uv[34:11], reference_now_uv[58:35],
	                            // apply_setting[59], zeros
	logic cfg_we = 1'b0;
	logic [23:0] cfg_wdata = '0;

	encoder_menu_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	emc_pkg::item_t pending_items[$];
	emc_pkg::result_t expected_screens[$];
	emc_pkg::item_t bus_item;
	bit item_taken = 1'b0;
	int errors = 0;
	int cycle_count = 0;
	int stimulus_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int ready_mode = 0;
	int ready_timer = 0;
	int hold_left = 0;

	logic [1:0] ui_depth = emc_pkg::LEVEL_ROOT;
	logic [1:0] ui_index = emc_pkg::MENU_VOLTAGE;
	logic [2:0] ui_cursor = 3'd0;
	logic [23:0] ui_setpoint = emc_pkg::SETPOINT_RESET;
	logic [23:0] ui_reference = emc_pkg::REFERENCE_RESET;
	logic [23:0] ui_limit = emc_pkg::LIMIT_RESET;
	logic [7:0] ui_last_enc = 8'd0;
	logic [1:0] ui_last_key = emc_pkg::KEY_NONE;
	logic ui_redraw = 1'b1;

	logic [7:0] gen_enc = 8'd0;
	logic [1:0] gen_key = emc_pkg::KEY_NONE;

	function automatic logic [23:0] nudge_uv(logic [23:0] value, logic [23:0] limit, int delta,
		logic [2:0] pos);
		longint step;
		longint cand;
		int i;
		step = 1;
		for (i = int'(pos); i < 6; i++)
			step = step * 10;
		cand = longint'(value) + longint'(delta) * step;
		if (cand < longint'(limit)) begin
			if (cand < 0)
				cand = 0;
			return cand[23:0];
		end
		return value;
	endfunction

	task automatic advance_menu(input emc_pkg::item_t it, output emc_pkg::result_t r);
		logic signed [7:0] diff8;
		int delta;
		int pos;
		logic apply;
		logic show;
		apply = 1'b0;
		show = 1'b0;
		if (it.action == emc_pkg::ACTION_LOAD) begin
			ui_setpoint = it.voltage_uv;
			ui_redraw = 1'b1;
		end else begin
			if (it.encoder_count != ui_last_enc || it.key_code != ui_last_key) begin
				diff8 = it.encoder_count - ui_last_enc;
				delta = int'(diff8);
				ui_last_enc = it.encoder_count;
				ui_last_key = it.key_code;
				if (delta != 0 || it.key_code != emc_pkg::KEY_NONE)
					ui_redraw = 1'b1;
				if (it.key_code == emc_pkg::KEY_OK_SHORT) begin
					if (ui_depth == emc_pkg::LEVEL_ADJUST)
						ui_depth = emc_pkg::LEVEL_SHOW;
					else if (ui_depth == emc_pkg::LEVEL_SHOW &&
							ui_index == emc_pkg::MENU_TEMPERATURE)
						ui_depth = emc_pkg::LEVEL_ROOT;
					else
						ui_depth = ui_depth + 2'd1;
				end else if (it.key_code == emc_pkg::KEY_OK_LONG) begin
					ui_depth = emc_pkg::LEVEL_ROOT;
				end else if (delta != 0) begin
					if (ui_depth == emc_pkg::LEVEL_LIST) begin
						pos = int'(ui_index) + delta;
						if (pos < 0)
							pos = 0;
						if (pos > 3)
							pos = 3;
						ui_index = pos[1:0];
					end else if (ui_depth == emc_pkg::LEVEL_SHOW &&
							ui_index != emc_pkg::MENU_TEMPERATURE) begin
						pos = int'(ui_cursor) + delta;
						if (pos < 0)
							pos = 0;
						if (ui_index == emc_pkg::MENU_CODE && pos > 4)
							pos = 4;
						if (pos > 6)
							pos = 6;
						ui_cursor = pos[2:0];
					end else if (ui_depth == emc_pkg::LEVEL_ADJUST) begin
						if (ui_index == emc_pkg::MENU_VOLTAGE) begin
							ui_setpoint = nudge_uv(ui_setpoint, ui_reference, delta, ui_cursor);
							apply = 1'b1;
						end else if (ui_index == emc_pkg::MENU_CALIBRATE) begin
							ui_reference = nudge_uv(ui_reference, ui_limit, delta, ui_cursor);
						end
					end
				end
			end
			show = ui_redraw;
			ui_redraw = 1'b0;
		end
		r.refresh = show;
		r.level = ui_depth;
		r.selected_menu = ui_index;
		if (ui_depth == emc_pkg::LEVEL_ROOT) begin
			r.cursor_led = emc_pkg::LED_ROOT;
			r.cursor_mode = emc_pkg::MODE_BLINK;
		end else if (ui_depth >= emc_pkg::LEVEL_SHOW &&
				ui_index != emc_pkg::MENU_TEMPERATURE) begin
			r.cursor_led = {1'b0, ui_cursor} +
				((ui_index == emc_pkg::MENU_CODE) ? CODE_DIGIT_OFFSET : VALUE_DIGIT_OFFSET);
			r.cursor_mode = (ui_depth == emc_pkg::LEVEL_SHOW) ?
				emc_pkg::MODE_HIGHLIGHT : emc_pkg::MODE_BLINK;
		end else begin
			r.cursor_led = emc_pkg::LED_NONE;
			r.cursor_mode = emc_pkg::MODE_NONE;
		end
		r.setting_uv = ui_setpoint;
		r.reference_now_uv = ui_reference;
		r.apply_setting = apply;
	endtask

	task automatic compare_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_screen(input emc_pkg::result_t got);
		emc_pkg::result_t want;
		if (expected_screens.size() == 0) begin
			$display("%0t: result with nothing expected, actual %h", $time, got);
			errors++;
		end else begin
			want = expected_screens.pop_front();
			compare_field("refresh", want.refresh, got.refresh);
			compare_field("level", want.level, got.level);
			compare_field("selected_menu", want.selected_menu, got.selected_menu);
			compare_field("cursor_led", want.cursor_led, got.cursor_led);
			compare_field("cursor_mode", want.cursor_mode, got.cursor_mode);
			compare_field("setting_uv", want.setting_uv, got.setting_uv);
			compare_field("reference_now_uv", want.reference_now_uv, got.reference_now_uv);
			compare_field("apply_setting", want.apply_setting, got.apply_setting);
		end
	endtask

	always @(posedge clk) begin
		emc_pkg::item_t seen;
		emc_pkg::result_t want;
		emc_pkg::result_t got;
		if (arst_n) begin
			cycle_count++;
			if (s_tvalid && s_tready) begin
				seen.action = s_tuser;
				seen.encoder_count = s_tdata[7:0];
				seen.key_code = s_tdata[9:8];
				seen.voltage_uv = s_tdata[33:10];
				advance_menu(seen, want);
				expected_screens.push_back(want);
				item_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				got.refresh = m_tdata[0];
				got.level = m_tdata[2:1];
				got.selected_menu = m_tdata[4:3];
				got.cursor_led = m_tdata[8:5];
				got.cursor_mode = m_tdata[10:9];
				got.setting_uv = m_tdata[34:11];
				got.reference_now_uv = m_tdata[58:35];
				got.apply_setting = m_tdata[59];
				check_screen(got);
			end
			if (cycle_count > CYCLE_LIMIT) begin
				$display("encoder_menu_controller: mismatch");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || item_taken)) begin
			item_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				bus_item = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= bus_item.action;
				s_tdata <= {6'd0, bus_item.voltage_uv, bus_item.key_code, bus_item.encoder_count};
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		logic ready;
		if (ready_timer == 0) begin
			ready_timer = 200;
			ready_mode = $urandom_range(0, 3);
		end
		ready_timer--;
		case (ready_mode)
			0: ready = 1'b1;
			1: ready = 1'($urandom_range(0, 1));
			2: ready = (ready_timer % 5) != 0;
			default: begin
				if (hold_left == 0 && $urandom_range(0, 7) == 0)
					hold_left = $urandom_range(1, 20);
				ready = (hold_left == 0);
				if (hold_left > 0)
					hold_left--;
			end
		endcase
		m_tready <= ready;
	end

	task automatic push_poll(input logic [7:0] enc, input logic [1:0] key);
		emc_pkg::item_t it;
		it.action = emc_pkg::ACTION_POLL;
		it.encoder_count = enc;
		it.key_code = key;
		it.voltage_uv = 24'($urandom_range(0, 15000000));
		gen_enc = enc;
		gen_key = key;
		pending_items.push_back(it);
		stimulus_count++;
	endtask

	task automatic push_load(input logic [23:0] volt);
		emc_pkg::item_t it;
		it.action = emc_pkg::ACTION_LOAD;
		it.encoder_count = 8'($urandom_range(0, 255));
		it.key_code = 2'($urandom_range(0, 3));
		it.voltage_uv = volt;
		pending_items.push_back(it);
		stimulus_count++;
	endtask

	task automatic turn(input int delta);
		push_poll(gen_enc + delta[7:0], gen_key);
	endtask

	task automatic tap(input logic [1:0] key);
		push_poll(gen_enc, key);
		push_poll(gen_enc, emc_pkg::KEY_NONE);
	endtask

	function automatic int pick_turn();
		int r;
		int mag;
		r = $urandom_range(0, 9);
		if (r < 6)
			mag = $urandom_range(1, 3);
		else if (r < 9)
			mag = $urandom_range(4, 20);
		else
			mag = $urandom_range(21, 128);
		if ($urandom_range(0, 1))
			return -mag;
		return (mag > 127) ? 127 : mag;
	endfunction

	task automatic walk_session();
		int target;
		int n;
		int i;
		case ($urandom_range(0, 5))
			0, 1: target = int'(emc_pkg::MENU_VOLTAGE);
			2, 3: target = int'(emc_pkg::MENU_CALIBRATE);
			4: target = int'(emc_pkg::MENU_CODE);
			default: target = int'(emc_pkg::MENU_TEMPERATURE);
		endcase
		tap(emc_pkg::KEY_OK_LONG);
		tap(emc_pkg::KEY_OK_SHORT);
		turn(-3);
		if (target > 0)
			turn(target);
		tap(emc_pkg::KEY_OK_SHORT);
		turn(-7);
		n = $urandom_range(0, 6);
		if (n > 0)
			turn(n);
		tap(emc_pkg::KEY_OK_SHORT);
		n = $urandom_range(2, 12);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_load(24'($urandom_range(0, 15000000)));
			else
				turn(pick_turn());
		end
		if ($urandom_range(0, 1))
			tap(emc_pkg::KEY_OK_SHORT);
	endtask

	task automatic push_noise();
		int n;
		int i;
		n = $urandom_range(1, 6);
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: push_poll(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
				1: push_poll(gen_enc, gen_key);
				2: push_poll(gen_enc + 8'(pick_turn()), 2'($urandom_range(0, 3)));
				default: turn(pick_turn());
			endcase
		end
	endtask

	task automatic write_limit(input logic [23:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		ui_limit = value;
	endtask

	task automatic drain_menu();
		while (pending_items.size() != 0 || s_tvalid || expected_screens.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [23:0] limits[5];
		int phase;
		int phase_end;
		limits = '{emc_pkg::LIMIT_RESET, 24'd10950000, 24'd1, 24'd12345678, 24'd15000000};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (phase = 0; phase < 5; phase++) begin
			write_limit(limits[phase]);
			if (phase == 0) begin
				push_poll(8'd0, emc_pkg::KEY_NONE);
				push_poll(8'd0, emc_pkg::KEY_NONE);
				push_load(24'd15000000);
				push_load(24'd0);
				push_poll(8'd5, emc_pkg::KEY_NONE);
				push_poll(8'd5, emc_pkg::KEY_OK_SHORT);
				push_poll(8'd5, emc_pkg::KEY_NONE);
				push_poll(8'd8, emc_pkg::KEY_NONE);
				push_poll(8'd8, emc_pkg::KEY_OK_SHORT);
				push_poll(8'd8, emc_pkg::KEY_NONE);
				push_poll(8'd9, emc_pkg::KEY_NONE);
				push_poll(8'd9, emc_pkg::KEY_OK_SHORT);
				push_poll(8'd9, KEY_OTHER);
				push_poll(8'd9, emc_pkg::KEY_OK_SHORT);
				push_poll(8'd9, emc_pkg::KEY_NONE);
				push_poll(8'd137, emc_pkg::KEY_NONE);
				push_poll(8'd137, emc_pkg::KEY_OK_SHORT);
				push_poll(8'd137, emc_pkg::KEY_NONE);
				push_poll(8'd255, emc_pkg::KEY_NONE);
				push_poll(8'd0, emc_pkg::KEY_NONE);
				push_poll(8'd0, emc_pkg::KEY_OK_SHORT);
				push_poll(8'd0, emc_pkg::KEY_NONE);
				push_load(24'd10899999);
				push_poll(8'd1, emc_pkg::KEY_NONE);
				push_poll(8'd128, emc_pkg::KEY_NONE);
				push_load(24'd5);
				push_poll(8'd121, emc_pkg::KEY_NONE);
				push_poll(8'd121, emc_pkg::KEY_OK_LONG);
			end
			phase_end = stimulus_count + PHASE_ITEMS;
			while (stimulus_count < phase_end) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: walk_session();
					7, 8: push_noise();
					default: push_load(24'($urandom_range(0, 15000000)));
				endcase
			end
			drain_menu();
		end
		if (errors == 0)
			$display("encoder_menu_controller: match");
		else
			$display("encoder_menu_controller: mismatch");
		$finish;
	end

endmodule

// File: files.f
rtl/emc_pkg.sv
rtl/emc_nudge.sv
rtl/emc_core.sv
rtl/encoder_menu_controller.sv
bench/encoder_menu_controller_tb.sv
